### hdl/mi_pkg.sv
// ----------------------------------------------------------------------------
// mi_pkg
// Shared constants for the 3x3 matrix inverse: port field width and the
// entry pairs that form each adjugate cofactor.
// ----------------------------------------------------------------------------
package mi_pkg;

    localparam int FIELD_W = 32;
    localparam int N_ENT   = 9;

    // Entries in row-major order: 0=a11 1=a12 2=a13 3=a21 ... 8=a33.
    // Cofactor k = a[CF_A[k]] * a[CF_B[k]] - a[CF_C[k]] * a[CF_D[k]]
    localparam logic [3:0] CF_A [N_ENT] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
    localparam logic [3:0] CF_B [N_ENT] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
    localparam logic [3:0] CF_C [N_ENT] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
    localparam logic [3:0] CF_D [N_ENT] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

endpackage

### hdl/mi_if.sv
// ----------------------------------------------------------------------------
// mi_if
// Valid/ready channels: matrix in, inverse out, and a generic record stream.
// ----------------------------------------------------------------------------
interface mi_in_if;
    import mi_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [FIELD_W-1:0]  m11, m12, m13, m21, m22, m23, m31, m32, m33;

    modport source (output valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
                    input ready);
    modport sink   (input valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
                    output ready);
endinterface

interface mi_out_if;
    import mi_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [FIELD_W-1:0]  r11, r12, r13, r21, r22, r23, r31, r32, r33;
    logic signed [FIELD_W-1:0]  determinant;
    logic                       singular;

    modport source (output valid, r11, r12, r13, r21, r22, r23, r31, r32, r33,
                    determinant, singular, input ready);
    modport sink   (input valid, r11, r12, r13, r21, r22, r23, r31, r32, r33,
                    determinant, singular, output ready);
endinterface

interface mi_stream_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### hdl/mat3_inverse.sv
// ----------------------------------------------------------------------------
// mat3_inverse
// Inverse and determinant of a 3x3 signed fixed-point matrix via adjugate.
// ----------------------------------------------------------------------------
// Pipeline: 7 cofactor/determinant stages, a two-entry queue and a divider that
//   resolves one quotient bit per stage.
// Throughput: one matrix per cycle while the output accepts results; nine dividers run side by side.
// Reset: synchronous; clears pipeline valid bits and the queue, no data reset.
// ----------------------------------------------------------------------------
module mat3_inverse #(
    parameter int FRAC_BITS   = 16,
    parameter int ENTRY_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mi_in_if.sink    i_in,
    mi_out_if.source o_out
);
    import mi_pkg::*;

    localparam int E     = ENTRY_WIDTH;
    localparam int REC_W = N_ENT * 2 * E + N_ENT + 3 * E + 1 + 2;

    mi_stream_if #(.W(REC_W)) front_q ();
    mi_stream_if #(.W(REC_W)) q_back ();

    mi_front #(.ENTRY_WIDTH(ENTRY_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_rec   (front_q)
    );

    mi_queue #(.W(REC_W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_q),
        .o_rd    (q_back)
    );

    mi_back #(.ENTRY_WIDTH(ENTRY_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (q_back),
        .o_out   (o_out)
    );

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.singular |->
            o_out.determinant == '0 && o_out.r11 == '0 && o_out.r22 == '0 && o_out.r33 == '0)
        else $error("singular result with nonzero entries");

    a_full_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_q.valid && !front_q.ready |-> q_back.valid)
        else $error("queue refuses a beat while empty");

    a_rst_idle: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out.valid && !q_back.valid)
        else $error("valid after reset");

endmodule

### hdl/mi_front.sv
// ----------------------------------------------------------------------------
// mi_front
// Cofactor and determinant pipeline: forms the nine cofactors, the
// full-precision determinant, its magnitude and the singular flag.
// ----------------------------------------------------------------------------
module mi_front #(
    parameter int ENTRY_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mi_in_if.sink       i_in,
    mi_stream_if.source o_rec
);
    import mi_pkg::*;

    localparam int E  = ENTRY_WIDTH;
    localparam int PW = 2 * E;
    localparam int CW = 2 * E + 1;
    localparam int DW = 3 * E + 2;
    localparam int NS = 7;

    logic [NS-1:0] r_v;
    logic          adv;

    logic signed [E-1:0]    r_a  [N_ENT];
    logic signed [PW-1:0]   r_p1 [N_ENT];
    logic signed [PW-1:0]   r_p2 [N_ENT];
    logic signed [E-1:0]    r_r2 [3];
    logic signed [CW-1:0]   r_c  [N_ENT];
    logic signed [E-1:0]    r_r3 [3];
    logic signed [2*E:0]    r_pl [3];
    logic signed [2*E:0]    r_ph [3];
    logic [N_ENT*PW-1:0]    r_cm4, r_cm5, r_cm6, r_cm7;
    logic [N_ENT-1:0]       r_cs4, r_cs5, r_cs6, r_cs7;
    logic signed [DW-1:0]   r_t  [3];
    logic signed [DW-1:0]   r_det;
    logic [DW-2:0]          r_dmag;
    logic                   r_dneg;
    logic                   r_sing;

    // Stall the whole chain only when the last stage holds a beat that the queue refuses
    assign adv         = !r_v[NS-1] || o_rec.ready;
    assign i_in.ready  = adv;
    assign o_rec.valid = r_v[NS-1];
    assign o_rec.data  = {r_sing, r_dneg, r_dmag, r_cs7, r_cm7};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[NS-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        logic [CW-1:0] neg_c;
        logic [DW-1:0] neg_d;
        if (adv) begin
            r_a[0] <= i_in.m11[E-1:0];
            r_a[1] <= i_in.m12[E-1:0];
            r_a[2] <= i_in.m13[E-1:0];
            r_a[3] <= i_in.m21[E-1:0];
            r_a[4] <= i_in.m22[E-1:0];
            r_a[5] <= i_in.m23[E-1:0];
            r_a[6] <= i_in.m31[E-1:0];
            r_a[7] <= i_in.m32[E-1:0];
            r_a[8] <= i_in.m33[E-1:0];

            for (int k = 0; k < N_ENT; k++) begin
                r_p1[k] <= r_a[CF_A[k]] * r_a[CF_B[k]];
                r_p2[k] <= r_a[CF_C[k]] * r_a[CF_D[k]];
            end
            for (int j = 0; j < 3; j++) begin
                r_r2[j] <= r_a[j];
                r_r3[j] <= r_r2[j];
            end

            for (int k = 0; k < N_ENT; k++) begin
                r_c[k] <= CW'(r_p1[k]) - CW'(r_p2[k]);
            end

            // Split each first-column cofactor into an unsigned low half and a signed high half
            for (int j = 0; j < 3; j++) begin
                r_pl[j] <= r_r3[j] * $signed({1'b0, r_c[3*j][E-1:0]});
                r_ph[j] <= r_r3[j] * $signed(r_c[3*j][CW-1:E]);
            end
            for (int k = 0; k < N_ENT; k++) begin
                neg_c = -r_c[k];
                r_cm4[k*PW +: PW] <= r_c[k][CW-1] ? neg_c[PW-1:0] : r_c[k][PW-1:0];
                r_cs4[k]          <= r_c[k][CW-1];
            end

            for (int j = 0; j < 3; j++) begin
                r_t[j] <= (DW'(r_ph[j]) <<< E) + DW'(r_pl[j]);
            end
            r_cm5 <= r_cm4;
            r_cs5 <= r_cs4;

            r_det <= r_t[0] + r_t[1] + r_t[2];
            r_cm6 <= r_cm5;
            r_cs6 <= r_cs5;

            neg_d  = -r_det;
            r_dmag <= r_det[DW-1] ? neg_d[DW-2:0] : r_det[DW-2:0];
            r_dneg <= r_det[DW-1];
            r_sing <= (r_det == '0);
            r_cm7  <= r_cm6;
            r_cs7  <= r_cs6;
        end
    end

endmodule

### hdl/mi_queue.sv
// ----------------------------------------------------------------------------
// mi_queue
// Two-entry FIFO between the cofactor front end and the divider back end.
// ----------------------------------------------------------------------------
module mi_queue #(
    parameter int W = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mi_stream_if.sink   i_wr,
    mi_stream_if.source o_rd
);
    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         push, pop;

    assign i_wr.ready = (r_cnt != 2'd2);
    assign o_rd.valid = (r_cnt != 2'd0);
    assign o_rd.data  = r_mem[r_rp];
    assign push       = i_wr.valid && i_wr.ready;
    assign pop        = o_rd.valid && o_rd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_wr.data;
    end

endmodule

### hdl/mi_back.sv
// ----------------------------------------------------------------------------
// mi_back
// Nine pipelined restoring dividers, one quotient bit per stage, followed by
// saturation and the result register.
// ----------------------------------------------------------------------------
module mi_back #(
    parameter int ENTRY_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mi_stream_if.sink  i_rec,
    mi_out_if.source   o_out
);
    import mi_pkg::*;

    localparam int E  = ENTRY_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * E;
    localparam int DW = 3 * E + 2;
    localparam int NW = PW + 2 * F;
    localparam int SW = DW - 1 + E;
    localparam int XW = (NW > SW) ? NW : SW;
    localparam int NS = E + 2;

    localparam logic [E-1:0] MAXP = {1'b0, {(E-1){1'b1}}};
    localparam logic [E-1:0] MINN = {1'b1, {(E-1){1'b0}}};

    logic [NS-1:0] r_v;
    logic          adv;

    logic [XW-1:0]    r_rem [E+1][N_ENT];
    logic [E-1:0]     r_q   [E+1][N_ENT];
    logic [N_ENT-1:0] r_ov  [E+1];
    logic [N_ENT-1:0] r_ng  [E+1];
    logic [DW-2:0]    r_dm  [E+1];
    logic             r_dn  [E+1];
    logic             r_sg  [E+1];

    logic [FIELD_W-1:0] r_res [N_ENT+1];
    logic               r_sing;

    logic [N_ENT*PW-1:0] in_cm;
    logic [N_ENT-1:0]    in_cs;
    logic [DW-2:0]       in_dm;
    logic                in_dn, in_sg;

    assign {in_sg, in_dn, in_dm, in_cs, in_cm} = i_rec.data;

    assign adv         = !r_v[NS-1] || o_out.ready;
    assign i_rec.ready = adv;
    assign o_out.valid = r_v[NS-1];

    assign o_out.r11         = r_res[0];
    assign o_out.r12         = r_res[1];
    assign o_out.r13         = r_res[2];
    assign o_out.r21         = r_res[3];
    assign o_out.r22         = r_res[4];
    assign o_out.r23         = r_res[5];
    assign o_out.r31         = r_res[6];
    assign o_out.r32         = r_res[7];
    assign o_out.r33         = r_res[8];
    assign o_out.determinant = r_res[N_ENT];
    assign o_out.singular    = r_sing;

    // Clamp an unsigned magnitude with sign to the signed entry range
    function automatic logic [E-1:0] sat(input logic [E-1:0] q, input logic ov,
                                         input logic neg);
        logic [E-1:0] v;
        if (!neg) begin
            v = (ov || q[E-1]) ? MAXP : q;
        end else begin
            v = (ov || (q[E-1] && (|q[E-2:0]))) ? MINN : -q;
        end
        return v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[NS-2:0], i_rec.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        logic [XW-1:0] num;
        logic [XW-1:0] dsh;
        logic          ge;
        logic [E-1:0]  qn;
        logic [DW-2:0] dq;
        if (adv) begin
            // Entry stage: flag quotients of 2^E or more up front
            for (int k = 0; k < N_ENT; k++) begin
                num = XW'(in_cm[k*PW +: PW]) << (2 * F);
                r_rem[0][k] <= num;
                r_q[0][k]   <= '0;
                r_ov[0][k]  <= (num >= (XW'(in_dm) << E));
                r_ng[0][k]  <= in_cs[k] ^ in_dn;
            end
            r_dm[0] <= in_dm;
            r_dn[0] <= in_dn;
            r_sg[0] <= in_sg;

            // One quotient bit per stage, most significant first
            for (int s = 1; s <= E; s++) begin
                for (int k = 0; k < N_ENT; k++) begin
                    dsh = XW'(r_dm[s-1]) << (E - s);
                    ge  = (r_rem[s-1][k] >= dsh);
                    qn  = r_q[s-1][k];
                    qn[E-s] = ge;
                    r_rem[s][k] <= ge ? (r_rem[s-1][k] - dsh) : r_rem[s-1][k];
                    r_q[s][k]   <= qn;
                end
                r_ov[s] <= r_ov[s-1];
                r_ng[s] <= r_ng[s-1];
                r_dm[s] <= r_dm[s-1];
                r_dn[s] <= r_dn[s-1];
                r_sg[s] <= r_sg[s-1];
            end

            for (int k = 0; k < N_ENT; k++) begin
                r_res[k] <= r_sg[E] ? '0
                          : FIELD_W'($signed(sat(r_q[E][k], r_ov[E][k], r_ng[E][k])));
            end
            dq = r_dm[E] >> (2 * F);
            r_res[N_ENT] <= r_sg[E] ? '0
                          : FIELD_W'($signed(sat(dq[E-1:0], (dq >> E) != '0, r_dn[E])));
            r_sing <= r_sg[E];
        end
    end

endmodule

### tb/sv/mat3_inverse_chk.sv
// ----------------------------------------------------------------------------
// mat3_inverse_chk
// Watches the matrix and inverse channels, computes the expected inverse,
// determinant and singular flag for each accepted matrix, and compares.
// ----------------------------------------------------------------------------
module mat3_inverse_chk
    import mi_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    mi_in_if.sink    i_in,
    mi_out_if.sink   i_out,
    output int       o_fail_cnt,
    output int       o_pending
);

    localparam int FRAC = 16;

    typedef struct packed {
        logic signed [FIELD_W-1:0] r11, r12, r13, r21, r22, r23, r31, r32, r33;
        logic signed [FIELD_W-1:0] det;
        logic                      sing;
    } inv_t;

    inv_t inv_q[$];

    // Clamp a signed wide value to the 32-bit signed range.
    function automatic logic signed [31:0] clamp32(input logic signed [159:0] v);
        if (v > 160'sd2147483647) return 32'sh7fffffff;
        if (v < -160'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic inv_t calc_inverse(input logic signed [31:0] a [9]);
        logic signed [159:0] w [9];
        logic signed [159:0] cof [9];
        logic signed [159:0] dw, q;
        logic signed [31:0]  r [9];
        inv_t e;
        for (int i = 0; i < 9; i++) w[i] = a[i];
        cof[0] = w[4]*w[8] - w[5]*w[7];
        cof[1] = w[2]*w[7] - w[1]*w[8];
        cof[2] = w[1]*w[5] - w[2]*w[4];
        cof[3] = w[5]*w[6] - w[3]*w[8];
        cof[4] = w[0]*w[8] - w[2]*w[6];
        cof[5] = w[2]*w[3] - w[0]*w[5];
        cof[6] = w[3]*w[7] - w[4]*w[6];
        cof[7] = w[1]*w[6] - w[0]*w[7];
        cof[8] = w[0]*w[4] - w[1]*w[3];
        dw = w[0]*cof[0] + w[1]*cof[3] + w[2]*cof[6];
        if (dw == 0) begin
            e = '0;
            e.sing = 1'b1;
            return e;
        end
        // signed division truncates toward zero
        for (int k = 0; k < 9; k++) begin
            q = (cof[k] <<< (2*FRAC)) / dw;
            r[k] = clamp32(q);
        end
        e.r11 = r[0]; e.r12 = r[1]; e.r13 = r[2];
        e.r21 = r[3]; e.r22 = r[4]; e.r23 = r[5];
        e.r31 = r[6]; e.r32 = r[7]; e.r33 = r[8];
        e.det = clamp32(dw / (160'sd1 <<< (2*FRAC)));
        e.sing = 1'b0;
        return e;
    endfunction

    task automatic cmp_field(input string nm, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", nm, exp_v, act_v);
            o_fail_cnt++;
        end
    endtask

    assign o_pending = inv_q.size();

    initial o_fail_cnt = 0;

    always @(posedge i_clk) begin
        logic signed [31:0] a [9];
        inv_t e;
        if (i_rst_n && i_in.valid && i_in.ready) begin
            a = '{i_in.m11, i_in.m12, i_in.m13, i_in.m21, i_in.m22, i_in.m23,
                  i_in.m31, i_in.m32, i_in.m33};
            inv_q.push_back(calc_inverse(a));
        end
        if (i_rst_n && i_out.valid && i_out.ready) begin
            if (inv_q.size() == 0) begin
                $error("result beat with no matrix outstanding");
                o_fail_cnt++;
            end else begin
                e = inv_q.pop_front();
                cmp_field("r11", e.r11, i_out.r11);
                cmp_field("r12", e.r12, i_out.r12);
                cmp_field("r13", e.r13, i_out.r13);
                cmp_field("r21", e.r21, i_out.r21);
                cmp_field("r22", e.r22, i_out.r22);
                cmp_field("r23", e.r23, i_out.r23);
                cmp_field("r31", e.r31, i_out.r31);
                cmp_field("r32", e.r32, i_out.r32);
                cmp_field("r33", e.r33, i_out.r33);
                cmp_field("determinant", e.det, i_out.determinant);
                cmp_field("singular", {31'd0, e.sing}, {31'd0, i_out.singular});
            end
        end
    end

endmodule

### tb/sv/mat3_inverse_tb.sv
// ----------------------------------------------------------------------------
// mat3_inverse_tb
// Drives directed and random matrices into the 3x3 inverse with random
// stalls on both channels, a long output hold-off and a drain pause; the
// checker predicts every result and reports mismatches.
// ----------------------------------------------------------------------------
module mat3_inverse_tb;
    import mi_pkg::*;

    localparam int N_RAND  = 1760;
    localparam int LATENCY = 42;

    logic i_clk;
    logic i_rst_n;
    int   fail_cnt;
    int   pending;
    bit   out_hold;
    bit   calm;

    mi_in_if  mat_if ();
    mi_out_if inv_if ();

    mat3_inverse DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (mat_if.sink),
        .o_out   (inv_if.source)
    );

    mat3_inverse_chk u_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (mat_if.sink),
        .i_out      (inv_if.sink),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    // Pick a random entry: mostly modest values, sometimes extremes or raw bits.
    function automatic logic [31:0] rand_entry();
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return 32'h7fffffff;
            2:       return 32'h80000000;
            3:       return 32'h0;
            4, 5:    return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            default: return $signed($urandom_range(0, 32'h1fffff)) - 32'sh100000;
        endcase
    endfunction

    // Offer one beat and hold until accepted; random gaps before it.
    task automatic send_mat(input logic [31:0] a [9]);
        if (!calm && $urandom_range(0, 5) == 0) begin
            mat_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        mat_if.valid <= 1'b1;
        {mat_if.m11, mat_if.m12, mat_if.m13, mat_if.m21, mat_if.m22, mat_if.m23,
         mat_if.m31, mat_if.m32, mat_if.m33} <= {a[0], a[1], a[2], a[3], a[4],
                                                a[5], a[6], a[7], a[8]};
        @(posedge i_clk);
        while (!mat_if.ready) @(posedge i_clk);
    endtask

    // Drop valid and hold until every result is back.
    task automatic drain();
        int wait_cnt;
        mat_if.valid <= 1'b0;
        wait_cnt = 0;
        do begin
            @(posedge i_clk);
            wait_cnt++;
        end while (pending != 0 && wait_cnt < 100000);
    endtask

    task automatic send_rand(input int kind);
        logic [31:0] a [9];
        for (int i = 0; i < 9; i++) a[i] = rand_entry();
        // make a row or column dependent so the singular path is hit
        if (kind == 1) begin
            a[6] = a[0]; a[7] = a[1]; a[8] = a[2];
        end else if (kind == 2) begin
            a[1] = a[0]; a[4] = a[3]; a[7] = a[6];
        end
        send_mat(a);
    endtask

    // Output side: random stalls, quiet at the end, long hold when asked.
    initial begin
        inv_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_hold) begin
                inv_if.ready <= 1'b0;
                repeat (150) @(posedge i_clk);
                out_hold = 1'b0;
                inv_if.ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                inv_if.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                inv_if.ready <= 1'b1;
            end else begin
                inv_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [31:0] a [9];
        mat_if.valid <= 1'b0;
        {mat_if.m11, mat_if.m12, mat_if.m13, mat_if.m21, mat_if.m22, mat_if.m23,
         mat_if.m31, mat_if.m32, mat_if.m33} <= '0;
        i_rst_n <= 1'b0;
        out_hold = 1'b0;
        calm = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: identity, zero, scaled identity, extremes, tiny det.
        a = '{32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000};
        send_mat(a);
        a = '{default: 32'h0};
        send_mat(a);
        a = '{default: 32'h10000};
        send_mat(a);
        a = '{32'h20000, 0, 0, 0, 32'hfffe0000, 0, 0, 0, 32'h8000};
        send_mat(a);
        a = '{32'h7fffffff, 0, 0, 0, 32'h7fffffff, 0, 0, 0, 32'h7fffffff};
        send_mat(a);
        a = '{32'h80000000, 0, 0, 0, 32'h80000000, 0, 0, 0, 32'h80000000};
        send_mat(a);
        a = '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
              32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff};
        send_mat(a);
        a = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
        send_mat(a);
        a = '{32'h100, 0, 0, 0, 32'h100, 0, 0, 0, 32'h100};
        send_mat(a);
        a = '{0, 32'h10000, 0, 32'h10000, 0, 0, 0, 0, 32'hffff0000};
        send_mat(a);
        a = '{32'h30000, 32'h10000, 32'h20000, 32'h60000, 32'h20000, 32'h40000,
              32'h10000, 32'h50000, 32'h70000};
        send_mat(a);
        a = '{default: 32'hffffffff};
        send_mat(a);
        a = '{32'h7fffffff, 32'h1, 32'h0, 32'h1, 32'h7fffffff, 32'h1, 32'h0, 32'h1, 1};
        send_mat(a);
        send_rand(0);
        send_rand(1);
        send_rand(2);

        // Block fills while the output holds off.
        out_hold = 1'b1;
        for (int n = 0; n < 120; n++) send_rand(0);

        for (int n = 0; n < N_RAND; n++) begin
            if (n == N_RAND / 2) begin
                // pause until every result is back
                drain();
            end
            if (n == N_RAND - 200) calm = 1'b1;
            send_rand($urandom_range(0, 11) == 0 ? $urandom_range(1, 2) : 0);
        end

        drain();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (fail_cnt == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### sim.f
hdl/mi_pkg.sv
hdl/mi_if.sv
hdl/mi_front.sv
hdl/mi_queue.sv
hdl/mi_back.sv
hdl/mat3_inverse.sv
tb/sv/mat3_inverse_chk.sv
tb/sv/mat3_inverse_tb.sv
